### src/crcf_pkg.sv
// Shared constants and types for the CRC-16 telemetry packet framer.
// No dependencies; compile this file first.
`default_nettype none

package crcf_pkg;

  // Frame layout: two sync bytes, eight payload bytes, two check bytes.
  localparam int unsigned FrameLen   = 12;
  localparam int unsigned PayloadLen = 8;
  localparam int unsigned PosWidth   = $clog2(FrameLen);

  typedef logic [PosWidth-1:0] pos_t;

  localparam pos_t POS_SYNC_A  = pos_t'(0);
  localparam pos_t POS_SYNC_B  = pos_t'(1);
  localparam pos_t POS_PAYLOAD = pos_t'(2);
  localparam pos_t POS_PAY_END = pos_t'(PayloadLen + 1);
  localparam pos_t POS_CRC_LO  = pos_t'(PayloadLen + 2);
  localparam pos_t POS_LAST    = pos_t'(FrameLen - 1);

  localparam logic [7:0] SYNC_A = 8'hAA;
  localparam logic [7:0] SYNC_B = 8'h55;

  // CRC-16/CCITT-FALSE: polynomial 0x1021, init 0xFFFF, no reflection.
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // One telemetry sample packed little-endian in send order.
  typedef logic [8*PayloadLen-1:0] payload_t;

endpackage

`default_nettype wire

### src/crcf_if.sv
// Valid/ready channel interfaces for the telemetry sample input and the
// frame byte output. Depends on nothing.
`default_nettype none

interface crcf_sample_if;
  logic               valid;
  logic               ready;
  logic        [31:0] time_ms;
  logic signed [15:0] drive_centi;
  logic signed [15:0] angle_centi;

  modport source (output valid, time_ms, drive_centi, angle_centi, input ready);
  modport sink   (input valid, time_ms, drive_centi, angle_centi, output ready);
endinterface

interface crcf_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, frame_byte, frame_end, input ready);
  modport sink   (input valid, frame_byte, frame_end, output ready);
endinterface

`default_nettype wire

### src/crcf_crc_step.sv
// One-byte update of the CRC-16/CCITT-FALSE remainder, MSB first.
// Depends on crcf_pkg for the polynomial.
`default_nettype none

module crcf_crc_step (
  input  wire logic [15:0] crc_i,
  input  wire logic [7:0]  data_i,
  output logic      [15:0] crc_o
);
  import crcf_pkg::*;

  // Fold the byte into the top of the remainder, then shift out eight bits.
  always_comb begin
    logic [15:0] acc;
    acc = crc_i ^ {data_i, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (acc[15]) begin
        acc = {acc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        acc = {acc[14:0], 1'b0};
      end
    end
    crc_o = acc;
  end

endmodule

`default_nettype wire

### src/crc16_telemetry_packet_framer_core.sv
// Top level of the CRC-16 telemetry packet framer.
// Depends on crcf_pkg, crcf_if.sv and crcf_crc_step.
//
// Usage:
//   smp_i takes one telemetry sample per transaction: a 32-bit timestamp in
//   milliseconds and two signed 16-bit values in hundredths. frm_o returns
//   the matching 12-byte frame, one byte per transaction: 0xAA, 0x55, the
//   timestamp, drive and angle little-endian, then the CRC-16/CCITT-FALSE
//   of those eight payload bytes, low byte first. frame_end marks the
//   twelfth byte.
//   The first byte of a frame passes from the sequencer into the output
//   register before it is offered. The sample rate is set by the byte-wide
//   output channel; the next sample is accepted in the cycle the last byte
//   of the current frame moves into the output register, so frames follow
//   each other with no gap. The CRC is built one byte per cycle, pausing while
//   the receiver stalls, as the payload bytes are sent.
//   Reset clears the sequencer and the output valid; no frame is pending.
//   When the receiver stalls, the output register holds its byte and the
//   sequencer waits; smp_i stays not ready until the frame can finish.
`default_nettype none

module crc16_telemetry_packet_framer_core (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  crcf_sample_if.sink    smp_i,
  crcf_frame_if.source   frm_o
);
  import crcf_pkg::*;

  logic        busy_q, busy_d;
  pos_t        pos_q, pos_d;
  payload_t    payload_q;
  logic [15:0] crc_q, crc_d, crc_next;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q;
  logic        out_end_q;

  logic        advance;
  logic        in_accept;
  logic [7:0]  cur_byte;
  logic [2:0]  pay_idx;

  // The sequencer moves on whenever the output register is free or drained.
  assign advance   = busy_q && (!out_valid_q || frm_o.ready);
  assign smp_i.ready = !busy_q || (advance && (pos_q == POS_LAST));
  assign in_accept = smp_i.valid && smp_i.ready;

  // Select the frame byte at the current position.
  assign pay_idx = 3'(pos_q - POS_PAYLOAD);
  always_comb begin
    case (pos_q)
      POS_SYNC_A: cur_byte = SYNC_A;
      POS_SYNC_B: cur_byte = SYNC_B;
      POS_CRC_LO: cur_byte = crc_q[7:0];
      POS_LAST:   cur_byte = crc_q[15:8];
      default:    cur_byte = payload_q[8*pay_idx +: 8];
    endcase
  end

  crcf_crc_step u_crc_step (
    .crc_i  (crc_q),
    .data_i (cur_byte),
    .crc_o  (crc_next)
  );

  // Sequencer and CRC accumulator next state.
  always_comb begin
    busy_d = busy_q;
    pos_d  = pos_q;
    crc_d  = crc_q;
    if (advance) begin
      if (pos_q == POS_LAST) begin
        busy_d = 1'b0;
        pos_d  = POS_SYNC_A;
      end else begin
        pos_d = pos_q + pos_t'(1);
      end
      if ((pos_q >= POS_PAYLOAD) && (pos_q <= POS_PAY_END)) begin
        crc_d = crc_next;
      end
    end
    if (in_accept) begin
      busy_d = 1'b1;
      pos_d  = POS_SYNC_A;
      crc_d  = CRC_INIT;
    end
  end

  // Output register valid: set by a byte from the sequencer, cleared when taken.
  always_comb begin
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (frm_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pos_q       <= POS_SYNC_A;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: sample, CRC and output byte.
  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
    if (in_accept) begin
      payload_q <= {smp_i.angle_centi, smp_i.drive_centi, smp_i.time_ms};
    end
    if (advance) begin
      out_byte_q <= cur_byte;
      out_end_q  <= (pos_q == POS_LAST);
    end
  end

  assign frm_o.valid      = out_valid_q;
  assign frm_o.frame_byte = out_byte_q;
  assign frm_o.frame_end  = out_end_q;

`ifndef ASSERT_OFF
  // A sample is taken only when no frame is left unfinished.
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> (!busy_q || (advance && (pos_q == POS_LAST))))
    else $error("sample accepted in the middle of a frame");

  // Every accepted sample starts a frame at the first sync byte.
  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (busy_q && (pos_q == POS_SYNC_A)))
    else $error("frame did not start after sample transaction");

  // The position never runs past the last byte and is at rest when idle.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q <= POS_LAST) && (busy_q || (pos_q == POS_SYNC_A)))
    else $error("byte position out of range");

  // Sending the last byte without a new sample leaves the sequencer idle.
  a_frame_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (pos_q == POS_LAST) && !in_accept) |=> !busy_q)
    else $error("sequencer still busy after the last byte");
`endif

endmodule

`default_nettype wire

### sim/tb_crc16_telemetry_packet_framer_core.sv
// Self-checking testbench for the CRC-16 telemetry packet framer core.
// Depends on crcf_pkg, the channel interfaces in crcf_if.sv and the framer core.
// Each accepted sample is turned into its expected 12-byte frame and checked byte by byte.
`default_nettype none

module tb_crc16_telemetry_packet_framer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import crcf_pkg::*;

  // One expected output transaction.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned SettleCycles = 16;

  logic clk_i = 1'b0;
  logic rst_ni;

  crcf_sample_if smp_if ();
  crcf_frame_if  frm_if ();

  crc16_telemetry_packet_framer_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .smp_i  (smp_if),
    .frm_o  (frm_if)
  );

  frame_beat_t expected_beats[$];
  int unsigned mismatch_count    = 0;
  int unsigned smp_idle_pct      = 18;
  int unsigned frm_idle_pct      = 18;
  int unsigned ready_hold_cycles = 0;
  int unsigned quiet_cycles      = 0;

  always #2 clk_i = ~clk_i;

  // CRC-16/CCITT-FALSE over the eight payload bytes, first byte in the low lane.
  function automatic logic [15:0] crc16_ccitt_false(input payload_t payload);
    logic [15:0] crc;
    crc = CRC_INIT;
    for (int i = 0; i < PayloadLen; i++) begin
      crc = crc ^ {payload[8*i +: 8], 8'h00};
      for (int k = 0; k < 8; k++) begin
        crc = crc[15] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
      end
    end
    return crc;
  endfunction

  // Builds the frame for one sample and appends its bytes to the expected queue.
  function automatic void push_frame_bytes(input logic [31:0] stamp,
                                           input logic [15:0] drive,
                                           input logic [15:0] angle);
    payload_t    payload;
    logic [15:0] crc;
    logic [7:0]  frame [FrameLen];
    payload = {angle, drive, stamp};
    crc     = crc16_ccitt_false(payload);
    frame[POS_SYNC_A] = SYNC_A;
    frame[POS_SYNC_B] = SYNC_B;
    for (int i = 0; i < PayloadLen; i++) begin
      frame[POS_PAYLOAD + i] = payload[8*i +: 8];
    end
    frame[POS_CRC_LO] = crc[7:0];
    frame[POS_LAST]   = crc[15:8];
    for (int i = 0; i < FrameLen; i++) begin
      expected_beats.push_back('{data: frame[i], last: (i == POS_LAST)});
    end
  endfunction

  // Signed value biased toward the ends of its range.
  function automatic logic [15:0] random_centi();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offers one sample after random idle cycles and waits for the transaction.
  // Valid stays high on return so the next sample can follow without a gap.
  task automatic send_sample(input logic [31:0] stamp,
                             input logic [15:0] drive,
                             input logic [15:0] angle);
    while ($urandom_range(99) < smp_idle_pct) begin
      smp_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    smp_if.valid       <= 1'b1;
    smp_if.time_ms     <= stamp;
    smp_if.drive_centi <= drive;
    smp_if.angle_centi <= angle;
    do @(posedge clk_i); while (!smp_if.ready);
    push_frame_bytes(stamp, drive, angle);
  endtask

  task automatic send_random_sample();
    logic [31:0] stamp;
    stamp = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF - $urandom_range(3) : $urandom;
    send_sample(stamp, random_centi(), random_centi());
  endtask

  // Stops offering samples and waits until every expected byte has arrived.
  task automatic wait_frames_sent();
    smp_if.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed_extremes();
    smp_idle_pct = 18;
    frm_idle_pct = 18;
    send_sample(32'h0000_0000, 16'h0000, 16'h0000);
    send_sample(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    send_sample(32'h8000_0000, 16'h8000, 16'h7FFF);
    send_sample(32'h7FFF_FFFF, 16'h7FFF, 16'h8000);
    send_sample(32'hAAAA_AAAA, 16'h5555, 16'hAAAA);
    send_sample(32'h5555_5555, 16'hAAAA, 16'h5555);
    // Payload bytes that look like sync bytes must pass through untouched.
    send_sample(32'h55AA_55AA, 16'h55AA, 16'hAA55);
    send_sample(32'h0000_0001, 16'h0001, 16'hFFFF);
    send_sample(32'hFFFF_FFFE, 16'hFF00, 16'h00FF);
  endtask

  task automatic test_random_samples(input int unsigned count);
    smp_idle_pct = 18;
    frm_idle_pct = 18;
    repeat (count) send_random_sample();
  endtask

  // Both sides always ready, so frames should follow each other with no gap.
  task automatic test_back_to_back(input int unsigned count);
    smp_idle_pct = 0;
    frm_idle_pct = 0;
    repeat (count) send_random_sample();
  endtask

  // The receiver holds off for a long stretch while samples keep coming,
  // so the framer fills up and has to stall its input.
  task automatic test_output_backpressure(input int unsigned count);
    smp_idle_pct      = 0;
    frm_idle_pct      = 18;
    ready_hold_cycles = 150;
    repeat (count) send_random_sample();
  endtask

  // The sender goes quiet until the framer has sent everything, then resumes.
  task automatic test_drain_pause(input int unsigned count);
    smp_idle_pct = 18;
    frm_idle_pct = 18;
    repeat (count) send_random_sample();
    wait_frames_sent();
    repeat (count) send_random_sample();
  endtask

  // Receiver side: random stalls, or a forced hold-off counted down here.
  always @(posedge clk_i) begin
    if (ready_hold_cycles > 0) begin
      frm_if.ready <= 1'b0;
      ready_hold_cycles--;
    end else begin
      frm_if.ready <= ($urandom_range(99) >= frm_idle_pct);
    end
  end

  // Compares every output transaction with the oldest expected byte.
  always @(posedge clk_i) begin : check_frame_byte
    frame_beat_t want;
    if (rst_ni && frm_if.valid && frm_if.ready) begin
      if (expected_beats.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected frame byte, expected none, actual %h end %b",
                 $time, frm_if.frame_byte, frm_if.frame_end);
      end else begin
        want = expected_beats.pop_front();
        if (frm_if.frame_byte !== want.data) begin
          mismatch_count++;
          $display("%0t: frame_byte mismatch, expected %h, actual %h",
                   $time, want.data, frm_if.frame_byte);
        end
        if (frm_if.frame_end !== want.last) begin
          mismatch_count++;
          $display("%0t: frame_end mismatch, expected %b, actual %b",
                   $time, want.last, frm_if.frame_end);
        end
      end
    end
  end

  // Ends the run if no transaction happens on either channel for too long.
  always @(posedge clk_i) begin
    if ((smp_if.valid && smp_if.ready) || (frm_if.valid && frm_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: no transaction for %0d cycles, %0d bytes still expected",
               $time, quiet_cycles, expected_beats.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni             = 1'b0;
    smp_if.valid       = 1'b0;
    smp_if.time_ms     = '0;
    smp_if.drive_centi = '0;
    smp_if.angle_centi = '0;
    frm_if.ready       = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_extremes();
    test_random_samples(100);
    test_back_to_back(40);
    test_output_backpressure(10);
    test_drain_pause(10);

    wait_frames_sent();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_beats.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
